/* rtl/pfb_pkg.sv */
`timescale 1ns / 1ps
package pfb_pkg;

  localparam int DisplayWidth  = 128;
  localparam int DisplayHeight = 64;
  localparam int PageCount     = (DisplayHeight + 7) / 8;
  localparam int StoreBytes    = DisplayWidth * PageCount;
  localparam int AddrW         = $clog2(StoreBytes);
  localparam int PageW         = $clog2(PageCount + 1);
  localparam int CharSteps     = 12;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_PIXEL  = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_CHAR   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PIX, ST_PIX_WR, ST_CHAR, ST_READ, ST_READ_DATA, ST_FINISH
  } state_t;

  typedef logic [0:4][6:0] glyph_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic       halted;
  } result_t;

  function automatic logic [6:0] rev7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[6 - i] = v[i];
    return r;
  endfunction

  // Look up the 5x7 shape; lowercase folds to uppercase, letters are bit-reversed
  function automatic glyph_t font_glyph(input logic [7:0] code_in);
    logic [7:0] c;
    glyph_t     g;
    c = code_in;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    case (c)
      8'h30: g = '{7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      8'h31: g = '{7'h00, 7'h21, 7'h7F, 7'h01, 7'h00};
      8'h32: g = '{7'h21, 7'h43, 7'h45, 7'h49, 7'h31};
      8'h33: g = '{7'h42, 7'h41, 7'h51, 7'h69, 7'h46};
      8'h34: g = '{7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04};
      8'h35: g = '{7'h72, 7'h51, 7'h51, 7'h51, 7'h4E};
      8'h36: g = '{7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      8'h37: g = '{7'h40, 7'h47, 7'h48, 7'h50, 7'h60};
      8'h38: g = '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      8'h39: g = '{7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      8'h41: g = '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      8'h42: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      8'h43: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      8'h44: g = '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      8'h45: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      8'h46: g = '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      8'h47: g = '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      8'h48: g = '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      8'h49: g = '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      8'h4A: g = '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      8'h4B: g = '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      8'h4C: g = '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      8'h4D: g = '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      8'h4E: g = '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      8'h4F: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      8'h50: g = '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      8'h51: g = '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      8'h52: g = '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      8'h53: g = '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      8'h54: g = '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      8'h55: g = '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      8'h56: g = '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      8'h57: g = '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
      8'h58: g = '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      8'h59: g = '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
      8'h5A: g = '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      8'h21: g = '{7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      8'h2E: g = '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      8'h2C: g = '{7'h00, 7'h02, 7'h1C, 7'h00, 7'h00};
      8'h3A: g = '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      8'h3B: g = '{7'h00, 7'h02, 7'h36, 7'h00, 7'h00};
      8'h2D: g = '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      8'h2B: g = '{7'h08, 7'h1C, 7'h08, 7'h1C, 7'h08};
      8'h2F: g = '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      8'h5F: g = '{7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      8'h3F: g = '{7'h20, 7'h40, 7'h4D, 7'h50, 7'h20};
      default: g = '0;
    endcase
    if (c >= 8'h41 && c <= 8'h5A) begin
      for (int k = 0; k < 5; k++) g[k] = rev7(g[k]);
    end
    return g;
  endfunction

endpackage

/* rtl/page_framebuffer_text_renderer_top.sv */
`timescale 1ns / 1ps
// Channel | Signals                                              | Direction
// input   | in_valid, in_stall, command, x, y, color, character, | into block
//         | read_index                                           |
// output  | out_valid, out_stall, read_data, halted              | out of block
//
// Items are handled one at a time; the single-port-pair frame store RAM sets the pace.
// Cursor, terminator, halted or halting character, off-screen pixel and unused codes go
// straight to the reply; a pixel reads then writes its byte; a byte read reads the store; a character
// makes twelve overlapped read-modify-write accesses plus one drain step; a clear sweeps the store.
// After reset the store is swept to zero with in_stall high.
// The result sits in an output register; the next item is taken while it waits.
module page_framebuffer_text_renderer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       color,
  input  logic [7:0] character,
  input  logic [9:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       halted
);
  import pfb_pkg::*;

  result_t          res;
  logic             res_free;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  assign res_free = !out_valid || !out_stall;

  pfb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .command, .x, .y, .color, .character,
    .read_index, .res_free, .res, .ram_we, .ram_waddr, .ram_wdata, .ram_raddr,
    .ram_rdata
  );

  pfb_ram #(.Width(8), .Depth(StoreBytes)) u_store (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
      read_data <= res.read_data;
      halted    <= res.halted;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule

/* rtl/pfb_ram.sv */
`timescale 1ns / 1ps
module pfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/pfb_ctrl.sv */
`timescale 1ns / 1ps
module pfb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             command,
  input  logic [7:0]             x,
  input  logic [7:0]             y,
  input  logic                   color,
  input  logic [7:0]             character,
  input  logic [9:0]             read_index,
  input  logic                   res_free,
  output pfb_pkg::result_t       res,
  output logic                   ram_we,
  output logic [pfb_pkg::AddrW-1:0] ram_waddr,
  output logic [7:0]             ram_wdata,
  output logic [pfb_pkg::AddrW-1:0] ram_raddr,
  input  logic [7:0]             ram_rdata
);
  import pfb_pkg::*;

  state_t           state, state_next;
  logic [AddrW-1:0] cnt;
  logic             clr_reply;
  logic [7:0]       fill;
  logic [7:0]       cursor_col, cursor_row;
  logic             stopped;
  glyph_t           glyph;
  logic [2:0]       shift;
  logic [7:0]       col_base;
  logic [PageW-1:0] page0;
  logic [AddrW-1:0] pix_idx;
  logic [7:0]       pix_mask;
  logic             pix_color;
  logic [AddrW-1:0] rd_idx;
  logic [7:0]       rdata;

  logic             accept;
  logic [7:0]       wcol, wrow;
  logic             wrap, stop_now;
  logic [3:0]       step;
  logic [AddrW-1:0] rd_acc_idx, wr_acc_idx;
  logic [7:0]       wr_mask, wr_bits, rd_mask_unused, rd_bits_unused;

  // Address, mask and data of one character access: column step[3:1], page half step[0]
  function automatic logic [AddrW+15:0] char_access(
      input logic [3:0] a, input logic [7:0] cb, input logic [PageW-1:0] pg,
      input logic [2:0] sh, input glyph_t gl);
    logic [2:0]       c;
    logic [7:0]       col;
    logic [PageW-1:0] p;
    logic [6:0]       bits;
    logic [14:0]      wide, wmask;
    logic [AddrW+PageW+7:0] idx;
    logic [7:0]       m, d;
    c    = a[3:1];
    col  = cb + {5'd0, c};
    p    = pg + {{(PageW-1){1'b0}}, a[0]};
    bits = (c < 3'd5) ? gl[c] : 7'd0;
    wide  = {8'd0, bits} << sh;
    wmask = 15'h007F << sh;
    idx  = (AddrW+PageW+8)'(p) * (AddrW+PageW+8)'(DisplayWidth) + (AddrW+PageW+8)'(col);
    m    = a[0] ? {1'b0, wmask[14:8]} : wmask[7:0];
    d    = a[0] ? {1'b0, wide[14:8]} : wide[7:0];
    return {idx[AddrW-1:0], m, d};
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign step     = cnt[3:0];

  // Wrap and bottom checks for a character at the cursor
  always_comb begin
    wrap     = ({1'b0, cursor_col} + 9'd5) >= 9'(DisplayWidth);
    wcol     = wrap ? 8'd0 : cursor_col;
    wrow     = wrap ? cursor_row + 8'd8 : cursor_row;
    stop_now = ({1'b0, wrow} + 9'd7) >= 9'(DisplayHeight);
  end

  assign {rd_acc_idx, rd_mask_unused, rd_bits_unused} =
      char_access(step, col_base, page0, shift, glyph);
  assign {wr_acc_idx, wr_mask, wr_bits} =
      char_access(step - 4'd1, col_base, page0, shift, glyph);

  // Next state and store ports
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = fill;
    ram_raddr  = rd_idx;
    res        = '{valid: 1'b0, read_data: rdata, halted: stopped};
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == AddrW'(StoreBytes - 1)) state_next = clr_reply ? ST_FINISH : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FINISH;
          case (command)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_PIXEL: if (x < 8'(DisplayWidth) && {1'b0, y} < 9'(DisplayHeight))
                         state_next = ST_PIX;
            CMD_CHAR:  if (character != 8'd0 && !stopped && !stop_now)
                         state_next = ST_CHAR;
            CMD_READ:  if ({1'b0, read_index} < 11'(StoreBytes)) state_next = ST_READ;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_PIX: begin
        ram_raddr  = pix_idx;
        state_next = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = pix_idx;
        ram_wdata  = (ram_rdata & ~pix_mask) | (pix_color ? pix_mask : 8'd0);
        state_next = ST_FINISH;
      end
      ST_CHAR: begin
        // Read access step while writing back access step-1
        ram_raddr = rd_acc_idx;
        if (step != 4'd0) begin
          ram_we    = (wr_mask != 8'd0);
          ram_waddr = wr_acc_idx;
          ram_wdata = (ram_rdata & ~wr_mask) | (wr_bits & wr_mask);
        end
        if (step == 4'(CharSteps)) state_next = ST_FINISH;
      end
      ST_READ:      state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_free) begin
          res.valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Hold cursor, flag and per-item working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      clr_reply  <= 1'b0;
      fill       <= 8'h00;
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      stopped    <= 1'b0;
    end else begin
      if (state == ST_CLEAR || state == ST_CHAR) cnt <= cnt + 1'b1;
      if (state == ST_READ_DATA) rdata <= ram_rdata;
      if (accept) begin
        cnt   <= '0;
        rdata <= 8'd0;
        case (command)
          CMD_CLEAR: begin
            clr_reply <= 1'b1;
            fill      <= color ? 8'hFF : 8'h00;
          end
          CMD_PIXEL: begin
            pix_idx   <= AddrW'(({3'd0, y} >> 3) * 11'(DisplayWidth) + {3'd0, x});
            pix_mask  <= 8'd1 << y[2:0];
            pix_color <= color;
          end
          CMD_CURSOR: begin
            cursor_col <= x;
            cursor_row <= y;
            stopped    <= 1'b0;
          end
          CMD_CHAR: begin
            if (character != 8'd0 && !stopped) begin
              cursor_col <= wcol;
              cursor_row <= wrow;
              if (stop_now) begin
                stopped <= 1'b1;
              end else begin
                cursor_col <= wcol + 8'd6;
                glyph      <= font_glyph(character);
                col_base   <= wcol;
                shift      <= wrow[2:0];
                page0      <= PageW'(wrow >> 3);
              end
            end
          end
          CMD_READ: rd_idx <= AddrW'(read_index);
          default: ;
        endcase
      end
    end
  end
endmodule

/* test/tb_page_framebuffer_text_renderer_top.sv */
`timescale 1ns / 1ps
module tb_page_framebuffer_text_renderer_top;
  import pfb_pkg::*;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic [7:0] character;
    logic [9:0] read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       halted;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = '0;
  logic [7:0] x = '0;
  logic [7:0] y = '0;
  logic       color = 1'b0;
  logic [7:0] character = '0;
  logic [9:0] read_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       halted;

  page_framebuffer_text_renderer_top DUT (.*);

  always #5 clk = ~clk;

  // Predictor state
  logic [7:0] pic_mem [StoreBytes];
  logic [7:0] cur_col, cur_row;
  logic       stopped;

  cmd_item_t  pending_items[$];
  reply_t     expected_replies[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_recv = 1'b0;
  bit         failed = 1'b0;

  // Font lookup, folded case, reversed letters; unknown codes blank
  function automatic logic [6:0] shape_col(input logic [7:0] code, input int k);
    logic [7:0]  c;
    logic [34:0] g;
    logic [6:0]  v, r;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    case (c)
      "0": g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      "1": g = {7'h00, 7'h21, 7'h7F, 7'h01, 7'h00};
      "2": g = {7'h21, 7'h43, 7'h45, 7'h49, 7'h31};
      "3": g = {7'h42, 7'h41, 7'h51, 7'h69, 7'h46};
      "4": g = {7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04};
      "5": g = {7'h72, 7'h51, 7'h51, 7'h51, 7'h4E};
      "6": g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      "7": g = {7'h40, 7'h47, 7'h48, 7'h50, 7'h60};
      "8": g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      "9": g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      "A": g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      "B": g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      "C": g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      "D": g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      "E": g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      "F": g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      "G": g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      "H": g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      "I": g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      "J": g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      "K": g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      "L": g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      "M": g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      "N": g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      "O": g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      "P": g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      "Q": g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      "R": g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      "S": g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      "T": g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      "U": g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      "V": g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      "W": g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
      "X": g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      "Y": g = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
      "Z": g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      "!": g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      ".": g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      ",": g = {7'h00, 7'h02, 7'h1C, 7'h00, 7'h00};
      ":": g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      ";": g = {7'h00, 7'h02, 7'h36, 7'h00, 7'h00};
      "-": g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      "+": g = {7'h08, 7'h1C, 7'h08, 7'h1C, 7'h08};
      "/": g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      "_": g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      "?": g = {7'h20, 7'h40, 7'h4D, 7'h50, 7'h20};
      default: g = '0;
    endcase
    v = g[34 - 7*k -: 7];
    r = v;
    if (c >= "A" && c <= "Z")
      for (int i = 0; i < 7; i++) r[6 - i] = v[i];
    return r;
  endfunction

  task automatic plot(input int px, input int py, input logic white);
    int idx;
    if (px >= DisplayWidth || py >= DisplayHeight) return;
    idx = px + (py / 8) * DisplayWidth;
    pic_mem[idx][py % 8] = white;
  endtask

  // Apply one command to the frame store model and queue its reply
  task automatic render_command(input cmd_item_t it);
    reply_t     rep;
    logic [6:0] bits;
    rep = '0;
    case (it.command)
      CMD_CLEAR: for (int i = 0; i < StoreBytes; i++) pic_mem[i] = {8{it.color}};
      CMD_PIXEL: plot(int'(it.x), int'(it.y), it.color);
      CMD_CURSOR: begin
        cur_col = it.x;
        cur_row = it.y;
        stopped = 1'b0;
      end
      CMD_CHAR: begin
        if (it.character != 8'd0 && !stopped) begin
          if (int'(cur_col) + 5 >= DisplayWidth) begin
            cur_col = '0;
            cur_row = cur_row + 8'd8;
          end
          if (int'(cur_row) + 7 >= DisplayHeight) begin
            stopped = 1'b1;
          end else begin
            for (int c = 0; c < 6; c++) begin
              bits = (c < 5) ? shape_col(it.character, c) : 7'h0;
              for (int r = 0; r < 7; r++) plot(int'(cur_col) + c, int'(cur_row) + r, bits[r]);
            end
            cur_col = cur_col + 8'd6;
          end
        end
      end
      CMD_READ: if (it.read_index < StoreBytes) rep.read_data = pic_mem[it.read_index];
      default: ;
    endcase
    rep.halted = stopped;
    expected_replies.push_back(rep);
  endtask

  // Driver: offer the next item, advance on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        render_command({command, x, y, color, character, read_index});
        void'(pending_items.pop_front());
      end
      if ((!in_valid || !in_stall) || !in_valid) begin
        if (in_valid && !in_stall) begin
          if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            {command, x, y, color, character, read_index} <= pending_items[0];
            in_valid <= 1'b1;
          end else begin
            in_valid <= 1'b0;
          end
        end else if (!in_valid && pending_items.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
          {command, x, y, color, character, read_index} <= pending_items[0];
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result read_data=%0h halted=%0b", read_data, halted);
          failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data expected %0h got %0h", want.read_data, read_data);
            failed = 1'b1;
          end
          if (halted !== want.halted) begin
            $error("halted expected %0b got %0b", want.halted, halted);
            failed = 1'b1;
          end
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic cmd_item_t make_item(input logic [2:0] cmd, input int px, input int py,
                                          input int col, input int ch, input int ri);
    cmd_item_t it;
    it.command = cmd;
    it.x = px[7:0];
    it.y = py[7:0];
    it.color = col[0];
    it.character = ch[7:0];
    it.read_index = ri[9:0];
    return it;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(cmd_item_t)-1:0];
    case ($urandom_range(9))
      0: it.command = CMD_CLEAR;
      1, 2: begin
        it.command = CMD_PIXEL;
        if ($urandom_range(3) != 0) begin
          it.x = 8'($urandom_range(DisplayWidth - 1));
          it.y = 8'($urandom_range(DisplayHeight - 1));
        end
      end
      3: begin
        it.command = CMD_CURSOR;
        if ($urandom_range(3) != 0) begin
          it.x = 8'($urandom_range(DisplayWidth - 1));
          it.y = 8'($urandom_range(DisplayHeight - 1));
        end
      end
      4, 5, 6: begin
        it.command = CMD_CHAR;
        if ($urandom_range(3) != 0) it.character = 8'($urandom_range(32, 122));
      end
      7, 8: begin
        it.command = CMD_READ;
        if ($urandom_range(3) != 0) it.read_index = 10'($urandom_range(StoreBytes - 1));
      end
      default: it.command = 3'($urandom_range(5, 7));
    endcase
    // Keep clears rare since each sweeps the store
    if (it.command == CMD_CLEAR && $urandom_range(3) != 0) it.command = CMD_READ;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int pct_send[4] = '{0, 70, 0, 26};
    int pct_recv[4] = '{0, 0, 70, 26};
    string msg;
    for (int i = 0; i < StoreBytes; i++) pic_mem[i] = '0;
    cur_col = '0;
    cur_row = '0;
    stopped = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every command, wrap, halt, terminator, unknown codes
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_PIXEL, 0, 0, 1, 0, 0));
    pending_items.push_back(make_item(CMD_PIXEL, 127, 63, 1, 0, 0));
    pending_items.push_back(make_item(CMD_PIXEL, 255, 255, 1, 0, 0));
    pending_items.push_back(make_item(CMD_PIXEL, 128, 10, 1, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 1023));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 1023 - 128 + 127));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "A", 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "z", 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, 255, 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "?", 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 1));
    pending_items.push_back(make_item(CMD_CURSOR, 123, 5, 0, 0, 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "7", 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 128));
    pending_items.push_back(make_item(CMD_CURSOR, 255, 56, 0, 0, 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "B", 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "C", 0));
    pending_items.push_back(make_item(CMD_CURSOR, 0, 250, 0, 0, 0));
    pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, "1", 0));
    pending_items.push_back(make_item(3'd7, 255, 255, 1, 255, 1023));
    pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 1, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 700));
    pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases over the idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(5) == 0) begin
          pending_items.push_back(make_item(CMD_CURSOR, $urandom_range(127),
                                            $urandom_range(63), 0, 0, 0));
          repeat ($urandom_range(3, 12))
            pending_items.push_back(make_item(CMD_CHAR, 0, 0, 0, $urandom_range(32, 127), 0));
        end
        pending_items.push_back(random_item());
      end
      wait_drained();
    end

    // Long receiver hold while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b1;
    for (int n = 0; n < 20; n++) pending_items.push_back(random_item());
    for (int k = 0; k < 300; k++) @(posedge clk);
    hold_recv = 1'b0;
    wait_drained();

    if (!failed) begin
      msg = "== PASS ==";
      $display(msg);
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
